// ===== sv/afp_pkg.sv =====
// Shared types and constants for the fixed partition fit allocator.
package afp_pkg;

	localparam int SIZE_FIELD_W = 16;
	localparam int INDEX_FIELD_W = 4;
	localparam int COUNTER_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_REQUEST = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

	localparam logic [COUNTER_W-1:0] COUNTER_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] action;
		logic [INDEX_FIELD_W-1:0] entry_index;
		logic [SIZE_FIELD_W-1:0] size;
	} item_t;

	typedef struct packed {
		logic [COUNTER_W-1:0] request_number;
		logic [SIZE_FIELD_W-1:0] request_size;
		logic granted;
		logic [INDEX_FIELD_W-1:0] chosen_index;
		logic [SIZE_FIELD_W-1:0] chosen_size;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear;
		logic begin_req;
		logic issue;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
	} stat_t;

endpackage

// ===== sv/afp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module afp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/afp_ctrl.sv =====
// Controller state machine: decodes items and sequences the partition scan.
module afp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] action,
	input  afp_pkg::stat_t stat,
	output afp_pkg::cmd_t cmd,
	output logic busy,
	output logic result_valid
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic busy_q;
	logic valid_q;
	logic accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign result_valid = valid_q;

	always_comb begin
		cmd = '0;
		if (accept) begin
			case (action)
				afp_pkg::ACT_LOAD: cmd.load = 1'b1;
				afp_pkg::ACT_REQUEST: cmd.begin_req = 1'b1;
				afp_pkg::ACT_CLEAR: cmd.clear = 1'b1;
				default: ;
			endcase
		end
		cmd.issue = (state_q == ST_SCAN) && !stat.scan_end;
		cmd.commit = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && action == afp_pkg::ACT_REQUEST) begin
						state_q <= ST_SCAN;
						busy_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					// The last compare lands on the same edge that leaves the scan.
					if (stat.scan_end) begin
						state_q <= ST_DONE;
						valid_q <= 1'b1;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					valid_q <= 1'b0;
					busy_q <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					valid_q <= 1'b0;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== sv/afp_dp.sv =====
// Datapath: configuration, partition table, scan pointer and fit selection.
module afp_dp #(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  afp_pkg::item_t item,
	input  logic cfg_write,
	input  logic [afp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [afp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  afp_pkg::cmd_t cmd,
	output afp_pkg::stat_t stat,
	output afp_pkg::result_t result
);

	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
	localparam int CMP_W = (SIZE_BITS > afp_pkg::SIZE_FIELD_W) ? SIZE_BITS
		: afp_pkg::SIZE_FIELD_W;

	logic [1:0] fit_mode_q;
	logic [4:0] block_count_q;
	logic [CNT_W-1:0] live_n;

	logic [MAX_PARTITIONS-1:0] in_use_q;
	logic [afp_pkg::COUNTER_W-1:0] counter_q;
	logic [afp_pkg::SIZE_FIELD_W-1:0] req_size_q;
	logic [CNT_W-1:0] ptr_q;
	logic cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic found_q;
	logic [IDX_W-1:0] pick_q;
	logic [CMP_W-1:0] pick_size_q;

	logic load_ok;
	logic [IDX_W-1:0] load_addr;
	logic [SIZE_BITS-1:0] load_data;
	logic [SIZE_BITS-1:0] rd_data;
	logic [CMP_W-1:0] cand_size;
	logic [CMP_W-1:0] req_ext;
	logic fits;
	logic take;

	always_comb begin
		if (int'(block_count_q) > MAX_PARTITIONS) begin
			live_n = CNT_W'(MAX_PARTITIONS);
		end else begin
			live_n = CNT_W'(block_count_q);
		end
	end

	assign stat.scan_end = (ptr_q == live_n);

	assign load_ok = cmd.load && (int'(item.entry_index) < MAX_PARTITIONS);
	assign load_addr = IDX_W'(item.entry_index);
	assign load_data = SIZE_BITS'(CMP_W'(item.size));

	afp_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_PARTITIONS)
	) u_sizes (
		.clk(clk),
		.we(load_ok),
		.waddr(load_addr),
		.wdata(load_data),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign cand_size = CMP_W'(rd_data);
	assign req_ext = CMP_W'(req_size_q);
	assign fits = cmp_valid_s1 && !in_use_q[cmp_idx_s1] && (cand_size >= req_ext);

	// First fit keeps the earliest candidate; any unused mode code behaves the same.
	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == afp_pkg::FIT_BEST) begin
				take = cand_size < pick_size_q;
			end else if (fit_mode_q == afp_pkg::FIT_WORST) begin
				take = cand_size > pick_size_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 2'd0;
			block_count_q <= 5'd0;
			in_use_q <= '0;
			counter_q <= '0;
			ptr_q <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					afp_pkg::CFG_FIT_MODE: fit_mode_q <= cfg_data[1:0];
					afp_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (load_ok) begin
				in_use_q[load_addr] <= 1'b0;
			end
			if (cmd.clear) begin
				in_use_q <= '0;
				counter_q <= '0;
			end
			if (cmd.begin_req) begin
				if (counter_q != afp_pkg::COUNTER_MAX) begin
					counter_q <= counter_q + 1'b1;
				end
				ptr_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			cmp_valid_s1 <= cmd.issue;
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.commit && found_q) begin
				in_use_q[pick_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= ptr_q[IDX_W-1:0];
		if (cmd.begin_req) begin
			req_size_q <= item.size;
			pick_q <= '0;
			pick_size_q <= '0;
		end else if (take) begin
			pick_q <= cmp_idx_s1;
			pick_size_q <= cand_size;
		end
	end

	assign result.request_number = counter_q;
	assign result.request_size = req_size_q;
	assign result.granted = found_q;
	assign result.chosen_index = afp_pkg::INDEX_FIELD_W'(pick_q);
	assign result.chosen_size = afp_pkg::SIZE_FIELD_W'(pick_size_q);

endmodule

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator.
// A load or clear transaction completes at the edge that accepts it and leaves busy low,
// so another item can follow in the next cycle. A request raises busy while the scan walks
// the first block_count entries of the partition table, block_count capped at MAX_PARTITIONS,
// one entry per cycle through the single read port of the size RAM, and then presents the
// result with result_valid high for a single cycle only, because the receiver cannot stall;
// the next item is accepted from the cycle after the strobe. Configuration writes are always
// ready and take effect at once.
module fixed_partition_fit_allocator #(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  afp_pkg::item_t item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [afp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [afp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic result_valid,
	output afp_pkg::result_t result
);

	afp_pkg::cmd_t cmd;
	afp_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	afp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(item.action),
		.stat(stat),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid)
	);

	afp_dp #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.SIZE_BITS(SIZE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat),
		.result(result)
	);

endmodule

// ===== sv/afp_checker.sv =====
// Port-level checker for the allocator and its bind to the top level.
module afp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input afp_pkg::item_t item,
	input logic result_valid,
	input afp_pkg::result_t result
);

	// A request transaction always keeps the block busy in the next cycle.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.action == afp_pkg::ACT_REQUEST |=> busy)
		else $error("request accepted without raising busy");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown outside a request");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.granted |->
			result.chosen_index == '0 && result.chosen_size == '0)
		else $error("refused request carries a partition");

	a_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.request_number != '0)
		else $error("request number is zero");

endmodule

bind fixed_partition_fit_allocator afp_checker u_afp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.item(item),
	.result_valid(result_valid),
	.result(result)
);
